>>> src/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg
// Shared constants, types and CORDIC helpers for the polar vector adder.
// ----------------------------------------------------------------------------
package pva_pkg;

	// configuration of the datapath
	localparam int LENGTH_BITS  = 16;
	localparam int CORDIC_STEPS = 16;

	// field widths
	localparam int LEN_W   = 16;
	localparam int ANG_W   = 17;
	localparam int XY_W    = 18;
	localparam int RLEN_W  = 17;
	localparam int RANG_W  = 16;

	// internal widths
	localparam int GAIN_W  = 24;
	localparam int M_W     = LENGTH_BITS + 16;
	localparam int CW      = LENGTH_BITS + 22;
	localparam int ZW      = 32;
	localparam int HI_W    = CW - 17;
	localparam int PH_W    = HI_W + GAIN_W;
	localparam int P_W     = PH_W + 1;

	// constants
	localparam int GAIN_Q24 = 10188014;
	localparam int DEG360   = 46080;
	localparam int DEG180   = 23040;
	localparam int DEG90    = 11520;
	localparam int ANGLE_UP = 13;
	localparam int SUM_MAX  = 131071;
	localparam int LEN_MAX  = 131071;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cvec_t;

	// atan(2^-i) in degrees, Q.20
	function automatic logic signed [ZW-1:0] atan_q20(input int i);
		logic signed [ZW-1:0] v;
		case (i)
			0:       v = ZW'(47185920);
			1:       v = ZW'(27855475);
			2:       v = ZW'(14718068);
			3:       v = ZW'(7471121);
			4:       v = ZW'(3750058);
			5:       v = ZW'(1876857);
			6:       v = ZW'(938658);
			7:       v = ZW'(469357);
			8:       v = ZW'(234682);
			9:       v = ZW'(117342);
			10:      v = ZW'(58671);
			11:      v = ZW'(29335);
			12:      v = ZW'(14668);
			13:      v = ZW'(7334);
			14:      v = ZW'(3667);
			15:      v = ZW'(1833);
			16:      v = ZW'(917);
			17:      v = ZW'(458);
			18:      v = ZW'(229);
			19:      v = ZW'(115);
			20:      v = ZW'(57);
			21:      v = ZW'(29);
			22:      v = ZW'(14);
			23:      v = ZW'(7);
			24:      v = ZW'(4);
			25:      v = ZW'(2);
			26:      v = ZW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

	// reduce an angle to [-180, +180) degrees
	function automatic logic signed [RANG_W-1:0] wrap_angle(input logic signed [ANG_W-1:0] a);
		logic signed [ANG_W:0] e;
		e = (ANG_W+1)'(a);
		if (e >= (ANG_W+1)'(DEG180)) begin
			e = e - (ANG_W+1)'(DEG360);
		end else if (e < -(ANG_W+1)'(DEG180)) begin
			e = e + (ANG_W+1)'(DEG360);
		end
		return e[RANG_W-1:0];
	endfunction

	// one rotation-mode iteration
	function automatic cvec_t rot_step(input cvec_t c, input int i);
		cvec_t r;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		dx = c.y >>> i;
		dy = c.x >>> i;
		if (!c.z[ZW-1]) begin
			r.x = c.x - dx;
			r.y = c.y + dy;
			r.z = c.z - atan_q20(i);
		end else begin
			r.x = c.x + dx;
			r.y = c.y - dy;
			r.z = c.z + atan_q20(i);
		end
		return r;
	endfunction

	// one vectoring-mode iteration
	function automatic cvec_t vec_step(input cvec_t c, input int i);
		cvec_t r;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		dx = c.y >>> i;
		dy = c.x >>> i;
		if (c.y[CW-1]) begin
			r.x = c.x - dx;
			r.y = c.y + dy;
			r.z = c.z - atan_q20(i);
		end else begin
			r.x = c.x + dx;
			r.y = c.y - dy;
			r.z = c.z + atan_q20(i);
		end
		return r;
	endfunction

	// round Q.16 component sum to integer with saturation
	function automatic logic signed [XY_W-1:0] round_sum(input logic signed [CW-1:0] s);
		logic signed [CW:0] t;
		logic signed [CW:0] lim;
		logic signed [XY_W-1:0] r;
		lim = (CW+1)'(SUM_MAX);
		t = (CW+1)'(s) + (CW+1)'(32768);
		t = t >>> 16;
		if (t > lim) begin
			r = XY_W'(SUM_MAX);
		end else if (t < -lim) begin
			r = -XY_W'(SUM_MAX);
		end else begin
			r = t[XY_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> src/pva_in_if.sv
// ----------------------------------------------------------------------------
// pva_in_if
// Input channel: two polar vectors per transfer.
// ----------------------------------------------------------------------------
interface pva_in_if;
	logic                                 valid;
	logic                                 ready;
	logic        [pva_pkg::LEN_W-1:0]     first_length;
	logic signed [pva_pkg::ANG_W-1:0]     first_angle;
	logic        [pva_pkg::LEN_W-1:0]     second_length;
	logic signed [pva_pkg::ANG_W-1:0]     second_angle;

	modport source (output valid, first_length, first_angle, second_length, second_angle,
		input ready);
	modport sink (input valid, first_length, first_angle, second_length, second_angle,
		output ready);
endinterface

>>> src/pva_out_if.sv
// ----------------------------------------------------------------------------
// pva_out_if
// Output channel: resultant vector in rectangular and polar form.
// ----------------------------------------------------------------------------
interface pva_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [pva_pkg::XY_W-1:0]      x_sum;
	logic signed [pva_pkg::XY_W-1:0]      y_sum;
	logic        [pva_pkg::RLEN_W-1:0]    result_length;
	logic signed [pva_pkg::RANG_W-1:0]    result_angle;

	modport source (output valid, x_sum, y_sum, result_length, result_angle, input ready);
	modport sink (input valid, x_sum, y_sum, result_length, result_angle, output ready);
endinterface

>>> src/polar_vector_adder.sv
// pipeline: multiply, rotation CORDIC, sum, vectoring CORDIC, magnitude and output stages, in that order
// throughput: one vector pair per cycle while rsp.ready holds; each CORDIC iteration is its own stage
// stalls: a stage holds only while it is full and its successor holds too, so bubbles close up
// reset: arst_n clears all stage valid bits asynchronously; payload is not reset
// ----------------------------------------------------------------------------
// polar_vector_adder
// Converts two polar vectors to rectangular form with rotation CORDICs, adds
// them, and recovers length and direction with a vectoring CORDIC.
// ----------------------------------------------------------------------------
module polar_vector_adder (
	input  logic          clk,
	input  logic          arst_n,
	pva_in_if.sink        req,
	pva_out_if.source     rsp
);

	localparam int CS  = pva_pkg::CORDIC_STEPS;
	localparam int NST = 2*CS + 4;
	localparam int CW  = pva_pkg::CW;
	localparam int ZW  = pva_pkg::ZW;
	localparam int GW  = pva_pkg::GAIN_W;
	localparam int LB  = pva_pkg::LENGTH_BITS;
	localparam int MW  = pva_pkg::M_W;
	localparam int XW  = pva_pkg::XY_W;

	// stage indexes
	localparam int ST_MUL = 0;
	localparam int ST_ROT = 1;
	localparam int ST_SUM = CS + 1;
	localparam int ST_VEC = CS + 2;
	localparam int ST_MAG = 2*CS + 2;
	localparam int ST_OUT = 2*CS + 3;

	logic [NST-1:0] vld;
	logic [NST-1:0] en;

	// stage payloads
	logic        [MW-1:0]                   m1_s1, m2_s1;
	logic signed [pva_pkg::RANG_W-1:0]      r1_s1, r2_s1;
	pva_pkg::cvec_t                         rot1_s2 [CS];
	pva_pkg::cvec_t                         rot2_s2 [CS];
	logic signed [CW-1:0]                   sx_s3, sy_s3;
	logic signed [XW-1:0]                   xs_s3, ys_s3;
	logic                                   nz_s3;
	pva_pkg::cvec_t                         vec_s4 [CS];
	logic signed [XW-1:0]                   xs_s4 [CS];
	logic signed [XW-1:0]                   ys_s4 [CS];
	logic                                   nz_s4 [CS];
	logic        [pva_pkg::PH_W-1:0]        phi_s5;
	logic        [GW-1:0]                   plo_s5;
	logic signed [pva_pkg::RANG_W-1:0]      ang_s5;
	logic signed [XW-1:0]                   xs_s5, ys_s5;
	logic                                   nz_s5;
	logic signed [XW-1:0]                   xs_s6, ys_s6;
	logic        [pva_pkg::RLEN_W-1:0]      len_s6;
	logic signed [pva_pkg::RANG_W-1:0]      ang_s6;

	// stage advance: a stage loads when empty or when its successor moves
	always_comb begin
		en[NST-1] = !vld[NST-1] || rsp.ready;
		for (int k = NST-2; k >= 0; k--) begin
			en[k] = !vld[k] || en[k+1];
		end
	end

	assign req.ready = en[0];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (en[k]) begin
					vld[k] <= (k == 0) ? req.valid : vld[(k == 0) ? 0 : k-1];
				end
			end
		end
	end

	// gain-corrected lengths and wrapped angles
	logic [LB+GW-1:0] p1, p2;
	always_comb begin
		p1 = (LB+GW)'(req.first_length[LB-1:0]) * (LB+GW)'(pva_pkg::GAIN_Q24)
			+ (LB+GW)'(128);
		p2 = (LB+GW)'(req.second_length[LB-1:0]) * (LB+GW)'(pva_pkg::GAIN_Q24)
			+ (LB+GW)'(128);
	end

	always_ff @(posedge clk) begin
		if (en[ST_MUL]) begin
			m1_s1 <= p1[LB+GW-1:8];
			m2_s1 <= p2[LB+GW-1:8];
			r1_s1 <= pva_pkg::wrap_angle(req.first_angle);
			r2_s1 <= pva_pkg::wrap_angle(req.second_angle);
		end
	end

	// quadrant pre-rotation by an exact swap
	function automatic pva_pkg::cvec_t rot_init(input logic [MW-1:0] m,
		input logic signed [pva_pkg::RANG_W-1:0] r);
		pva_pkg::cvec_t c;
		logic signed [CW-1:0] ms;
		logic signed [pva_pkg::RANG_W-1:0] rr;
		ms = CW'(m);
		rr = r;
		c.x = ms;
		c.y = '0;
		if (r > pva_pkg::RANG_W'(pva_pkg::DEG90)) begin
			c.x = '0;
			c.y = ms;
			rr = r - pva_pkg::RANG_W'(pva_pkg::DEG90);
		end else if (r < -pva_pkg::RANG_W'(pva_pkg::DEG90)) begin
			c.x = '0;
			c.y = -ms;
			rr = r + pva_pkg::RANG_W'(pva_pkg::DEG90);
		end
		c.z = ZW'(rr) <<< pva_pkg::ANGLE_UP;
		return c;
	endfunction

	// rotation CORDIC, one iteration per stage
	for (genvar i = 0; i < CS; i++) begin : g_rot
		pva_pkg::cvec_t a1, a2;
		always_comb begin
			if (i == 0) begin
				a1 = rot_init(m1_s1, r1_s1);
				a2 = rot_init(m2_s1, r2_s1);
			end else begin
				a1 = rot1_s2[(i == 0) ? 0 : i-1];
				a2 = rot2_s2[(i == 0) ? 0 : i-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en[ST_ROT+i]) begin
				rot1_s2[i] <= pva_pkg::rot_step(a1, i);
				rot2_s2[i] <= pva_pkg::rot_step(a2, i);
			end
		end
	end

	// component sums and rounded outputs
	logic signed [CW-1:0] sx, sy;
	assign sx = rot1_s2[CS-1].x + rot2_s2[CS-1].x;
	assign sy = rot1_s2[CS-1].y + rot2_s2[CS-1].y;

	always_ff @(posedge clk) begin
		if (en[ST_SUM]) begin
			sx_s3 <= sx;
			sy_s3 <= sy;
			xs_s3 <= pva_pkg::round_sum(sx);
			ys_s3 <= pva_pkg::round_sum(sy);
			nz_s3 <= (pva_pkg::round_sum(sx) != '0) || (pva_pkg::round_sum(sy) != '0);
		end
	end

	// left half plane folds into the right one with a 180 degree start, signed as y
	pva_pkg::cvec_t vinit;
	always_comb begin
		vinit.x = sx_s3;
		vinit.y = sy_s3;
		vinit.z = '0;
		if (sx_s3[CW-1]) begin
			vinit.x = -sx_s3;
			vinit.y = -sy_s3;
			vinit.z = sy_s3[CW-1] ? -(ZW'(pva_pkg::DEG180) <<< pva_pkg::ANGLE_UP)
				: (ZW'(pva_pkg::DEG180) <<< pva_pkg::ANGLE_UP);
		end
	end

	// vectoring CORDIC, one iteration per stage
	for (genvar i = 0; i < CS; i++) begin : g_vec
		pva_pkg::cvec_t       a;
		logic signed [XW-1:0] xs, ys;
		logic                 nz;
		always_comb begin
			if (i == 0) begin
				a  = vinit;
				xs = xs_s3;
				ys = ys_s3;
				nz = nz_s3;
			end else begin
				a  = vec_s4[(i == 0) ? 0 : i-1];
				xs = xs_s4[(i == 0) ? 0 : i-1];
				ys = ys_s4[(i == 0) ? 0 : i-1];
				nz = nz_s4[(i == 0) ? 0 : i-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en[ST_VEC+i]) begin
				vec_s4[i] <= pva_pkg::vec_step(a, i);
				xs_s4[i]  <= xs;
				ys_s4[i]  <= ys;
				nz_s4[i]  <= nz;
			end
		end
	end

	// gain correction of the magnitude, split into two products
	localparam int HI_W_L = pva_pkg::HI_W;
	logic        [CW-2:0]           ux;
	logic        [HI_W_L-1:0]       uhi;
	logic        [pva_pkg::PH_W-1:0] phi;
	logic        [GW+15:0]          plo;
	logic signed [ZW:0]             zr;
	logic signed [ZW:0]             zlim;
	logic signed [pva_pkg::RANG_W-1:0] ang;

	always_comb begin
		ux   = vec_s4[CS-1].x[CW-1] ? '0 : vec_s4[CS-1].x[CW-2:0];
		uhi  = ux[CW-2:16];
		phi  = pva_pkg::PH_W'(uhi) * pva_pkg::PH_W'(pva_pkg::GAIN_Q24);
		plo  = (GW+16)'(ux[15:0]) * (GW+16)'(pva_pkg::GAIN_Q24);
		zlim = (ZW+1)'(pva_pkg::DEG180);
		zr   = (ZW+1)'(vec_s4[CS-1].z) + (ZW+1)'(4096);
		zr   = zr >>> pva_pkg::ANGLE_UP;
		if (zr > zlim) begin
			ang = pva_pkg::RANG_W'(pva_pkg::DEG180);
		end else if (zr < -zlim) begin
			ang = -pva_pkg::RANG_W'(pva_pkg::DEG180);
		end else begin
			ang = zr[pva_pkg::RANG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_MAG]) begin
			phi_s5 <= phi;
			plo_s5 <= plo[GW+15:16];
			ang_s5 <= ang;
			xs_s5  <= xs_s4[CS-1];
			ys_s5  <= ys_s4[CS-1];
			nz_s5  <= nz_s4[CS-1];
		end
	end

	// final rounding and saturation of the length
	logic [pva_pkg::P_W-1:0] psum;
	logic [pva_pkg::P_W-25:0] lraw;
	logic [pva_pkg::RLEN_W-1:0] lsat;
	always_comb begin
		psum = pva_pkg::P_W'(phi_s5) + pva_pkg::P_W'(plo_s5) + pva_pkg::P_W'(1 << 23);
		lraw = psum[pva_pkg::P_W-1:24];
		if (lraw > (pva_pkg::P_W-24)'(pva_pkg::LEN_MAX)) begin
			lsat = pva_pkg::RLEN_W'(pva_pkg::LEN_MAX);
		end else begin
			lsat = lraw[pva_pkg::RLEN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_OUT]) begin
			xs_s6  <= xs_s5;
			ys_s6  <= ys_s5;
			len_s6 <= nz_s5 ? lsat : '0;
			ang_s6 <= nz_s5 ? ang_s5 : '0;
		end
	end

	assign rsp.valid         = vld[NST-1];
	assign rsp.x_sum         = xs_s6;
	assign rsp.y_sum         = ys_s6;
	assign rsp.result_length = len_s6;
	assign rsp.result_angle  = ang_s6;

endmodule

>>> src/pva_checker.sv
// ----------------------------------------------------------------------------
// pva_checker
// Port-level checks on the polar vector adder, bound to the top level.
// ----------------------------------------------------------------------------
module pva_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [pva_pkg::XY_W-1:0]       x_sum,
	input logic signed [pva_pkg::XY_W-1:0]       y_sum,
	input logic        [pva_pkg::RLEN_W-1:0]     result_length,
	input logic signed [pva_pkg::RANG_W-1:0]     result_angle
);

	// an empty output stage never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output stage empty");

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its value
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(x_sum) && $stable(y_sum)
			&& $stable(result_length) && $stable(result_angle))
		else $error("result changed while stalled");

	// zero sum gives zero length and angle
	a_zero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && x_sum == '0 && y_sum == '0 |-> result_length == '0
			&& result_angle == '0)
		else $error("nonzero polar result for zero sum");

	// direction stays within half a turn
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> result_angle <= 16'sd23040 && result_angle >= -16'sd23040)
		else $error("result angle out of range");

endmodule

bind polar_vector_adder pva_checker u_pva_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (req.ready),
	.out_valid     (rsp.valid),
	.out_ready     (rsp.ready),
	.x_sum         (rsp.x_sum),
	.y_sum         (rsp.y_sum),
	.result_length (rsp.result_length),
	.result_angle  (rsp.result_angle)
);
